>>> hdl/ksess_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksess_pkg
// Types and codes shared by the session table modules.
// ----------------------------------------------------------------------------
package ksess_pkg;

    localparam int KEY_W      = 64;
    localparam int LEN_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int FREED_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [STATUS_W-1:0] STAT_REFRESHED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_CREATED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_LENGTH = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SWEEP      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_LIMIT     = 2'd1;

    localparam logic [LEN_W-1:0]   KEEPALIVE_LENGTH_RST = 16'd4;
    localparam logic [STAMP_W-1:0] EXPIRE_LIMIT_RST     = 32'd3000;

    localparam logic [FREED_W-1:0] FREED_MAX = 5'd31;

    localparam logic FUNC_KEEPALIVE = 1'b0;
    localparam logic FUNC_SWEEP     = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   client_key;
        logic [LEN_W-1:0]   packet_length;
        logic [STAMP_W-1:0] client_stamp;
        logic [STAMP_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                reply_valid;
        logic [STAMP_W-1:0]  echo_stamp;
        logic [STAMP_W-1:0]  server_stamp;
        logic [FREED_W-1:0]  freed_count;
    } result_t;

endpackage
`default_nettype wire

>>> hdl/ksess_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksess_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ksess_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> hdl/ksess_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksess_ctrl
// Sequencer that walks the table one slot per cycle through a shared key
// compare and age compare unit, and holds the per-slot valid bits.
// ----------------------------------------------------------------------------
module ksess_ctrl
    import ksess_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire item_t              in_item,
    input  wire logic [LEN_W-1:0]   keepalive_length,
    input  wire logic [STAMP_W-1:0] expire_limit,
    output logic      [IDX_W-1:0]   rd_addr,
    input  wire logic [KEY_W-1:0]   key_q,
    input  wire logic [STAMP_W-1:0] seen_q,
    output logic                    key_wr_en,
    output logic                    seen_wr_en,
    output logic      [IDX_W-1:0]   wr_addr,
    output logic                    res_valid,
    output result_t                 res,
    input  wire logic               res_take
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    result_t                res_reg, res_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [FREED_W-1:0]     freed_reg, freed_next;

    logic                   slot_valid;
    logic                   key_hit;
    logic [STAMP_W-1:0]     age;
    logic                   expired;
    logic                   have_free;
    logic [IDX_W-1:0]       free_pick;

    // shared compare unit: one slot per cycle
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign key_hit    = slot_valid && (key_q == item_reg.client_key);
    assign age        = item_reg.now - seen_q;
    assign expired    = slot_valid && (age > expire_limit);
    assign have_free  = free_found_reg || !slot_valid;
    assign free_pick  = free_found_reg ? free_idx_reg : cmp_idx_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign rd_addr   = idx_reg;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        res_reg        <= res_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        freed_reg      <= freed_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        freed_next      = freed_reg;
        key_wr_en       = 1'b0;
        seen_wr_en      = 1'b0;
        wr_addr         = cmp_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_item;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    free_found_next = 1'b0;
                    freed_next      = '0;
                    if (in_item.func == FUNC_KEEPALIVE &&
                        in_item.packet_length != keepalive_length)
                    begin
                        res_next        = '0;
                        res_next.status = STAT_BAD_LENGTH;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue reads, compare each slot in the cycle after its read is issued
                if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end

                if (cmp_vld_reg)
                begin
                    if (item_reg.func == FUNC_SWEEP)
                    begin
                        if (expired)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            if (freed_reg != FREED_MAX)
                            begin
                                freed_next = freed_reg + 1'b1;
                            end
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            res_next             = '0;
                            res_next.status      = STAT_SWEEP;
                            res_next.freed_count = (expired && freed_reg != FREED_MAX) ?
                                                   freed_reg + 1'b1 : freed_reg;
                            state_next           = S_DONE;
                        end
                    end
                    else if (key_hit)
                    begin
                        seen_wr_en            = 1'b1;
                        wr_addr               = cmp_idx_reg;
                        res_next.status       = STAT_REFRESHED;
                        res_next.slot         = SLOT_W'(cmp_idx_reg);
                        res_next.reply_valid  = 1'b1;
                        res_next.echo_stamp   = item_reg.client_stamp;
                        res_next.server_stamp = item_reg.now;
                        res_next.freed_count  = '0;
                        state_next            = S_DONE;
                    end
                    else
                    begin
                        if (!slot_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            res_next = '0;
                            if (have_free)
                            begin
                                key_wr_en             = 1'b1;
                                seen_wr_en            = 1'b1;
                                wr_addr               = free_pick;
                                valid_next[free_pick] = 1'b1;
                                res_next.status       = STAT_CREATED;
                                res_next.slot         = SLOT_W'(free_pick);
                                res_next.reply_valid  = 1'b1;
                                res_next.echo_stamp   = item_reg.client_stamp;
                                res_next.server_stamp = item_reg.now;
                            end
                            else
                            begin
                                res_next.status = STAT_FULL;
                            end
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/keepalive_session_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keepalive_session_table
// Session table with keepalive refresh/create and expiry sweep.
// A sweep or a missed keepalive shows its result once the scan has passed
// every slot, a hit on slot k once the scan reaches slot k, and a
// bad-length packet without any scan.
// A new item is taken only once the last result has left the sequencer;
// the scan reads one slot per cycle from the key and last-seen RAMs.
// Reset: valid bits clear at once, registers return to length 4 and limit
// 3000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keepalive_session_table
    import ksess_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  func,
    input  wire logic [KEY_W-1:0]      client_key,
    input  wire logic [LEN_W-1:0]      packet_length,
    input  wire logic [STAMP_W-1:0]    client_stamp,
    input  wire logic [STAMP_W-1:0]    now,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [STATUS_W-1:0]   status,
    output logic      [SLOT_W-1:0]     slot,
    output logic                       reply_valid,
    output logic      [STAMP_W-1:0]    echo_stamp,
    output logic      [STAMP_W-1:0]    server_stamp,
    output logic      [FREED_W-1:0]    freed_count
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic [LEN_W-1:0]   keepalive_length_reg;
    logic [STAMP_W-1:0] expire_limit_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    item_t              in_item;
    result_t            res;
    logic               res_valid;
    logic               res_take;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               key_wr_en;
    logic               seen_wr_en;
    logic [KEY_W-1:0]   key_q;
    logic [STAMP_W-1:0] seen_q;

    // hold the key and time of the word in flight for the table writes
    logic [KEY_W-1:0]   in_item_key_hold;
    logic [STAMP_W-1:0] now_hold;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keepalive_length_reg <= KEEPALIVE_LENGTH_RST;
            expire_limit_reg     <= EXPIRE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEEPALIVE_LENGTH: keepalive_length_reg <= cfg_data[LEN_W-1:0];
                CFG_EXPIRE_LIMIT:     expire_limit_reg     <= cfg_data[STAMP_W-1:0];
                default:              ;
            endcase
        end
    end

    assign in_item.func          = func;
    assign in_item.client_key    = client_key;
    assign in_item.packet_length = packet_length;
    assign in_item.client_stamp  = client_stamp;
    assign in_item.now           = now;

    ksess_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .keepalive_length (keepalive_length_reg),
        .expire_limit     (expire_limit_reg),
        .rd_addr          (rd_addr),
        .key_q            (key_q),
        .seen_q           (seen_q),
        .key_wr_en        (key_wr_en),
        .seen_wr_en       (seen_wr_en),
        .wr_addr          (wr_addr),
        .res_valid        (res_valid),
        .res              (res),
        .res_take         (res_take)
    );

    ksess_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS),
        .AW    (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_item_key_hold),
        .rd_addr (rd_addr),
        .rd_data (key_q)
    );

    ksess_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (TABLE_SLOTS),
        .AW    (IDX_W)
    ) u_seen_ram (
        .clk     (clk),
        .wr_en   (seen_wr_en),
        .wr_addr (wr_addr),
        .wr_data (now_hold),
        .rd_addr (rd_addr),
        .rd_data (seen_q)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_key_hold <= client_key;
            now_hold         <= now;
        end
    end

    // output register frees the sequencer while a result waits
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign slot         = out_reg.slot;
    assign reply_valid  = out_reg.reply_valid;
    assign echo_stamp   = out_reg.echo_stamp;
    assign server_stamp = out_reg.server_stamp;
    assign freed_count  = out_reg.freed_count;

endmodule
`default_nettype wire
